/* design/sfc_pkg.sv */
// shared types and constants of the single-precision float coprocessor
// no dependencies; imported by the controller, the datapath and the top level
package sfc_pkg;

   localparam logic [31:0] ExpMask   = 32'h7F80_0000;
   localparam logic [31:0] SignMask  = 32'h8000_0000;
   localparam logic [31:0] MaxFinite = 32'h7F7F_FFFF;
   localparam logic [31:0] Ctrl0Word = 32'h0000_2E00;
   localparam logic [31:0] QnanWord  = 32'h7FC0_0000;

   // working significand: bit 48 weighs 1.0, bit 49 catches carry out
   localparam int ManW     = 50;
   localparam int DivSteps = 27;
   localparam int CntW     = 5;
   localparam int RegCount = 32;
   localparam int RegAddrW = 5;

   typedef logic signed [10:0] exp_type;
   typedef logic [ManW-1:0]    man_type;

   typedef enum logic [3:0] {
      OP_MTC   = 4'd0,
      OP_MFC   = 4'd1,
      OP_CFC   = 4'd2,
      OP_CTC   = 4'd3,
      OP_CVTSW = 4'd4,
      OP_CVTWS = 4'd5,
      OP_ADD   = 4'd6,
      OP_SUB   = 4'd7,
      OP_MUL   = 4'd8,
      OP_DIV   = 4'd9,
      OP_MOV   = 4'd10,
      OP_NEG   = 4'd11,
      OP_ADDA  = 4'd12,
      OP_MADD  = 4'd13,
      OP_CLT   = 4'd14,
      OP_CEQ   = 4'd15
   } opcode_type;

   typedef enum logic [3:0] {
      CMD_NONE     = 4'd0,
      CMD_LOAD     = 4'd1,
      CMD_SIMPLE   = 4'd2,
      CMD_UNPACK   = 4'd3,
      CMD_MUL      = 4'd4,
      CMD_DIV_STEP = 4'd5,
      CMD_DIV_END  = 4'd6,
      CMD_ALIGN    = 4'd7,
      CMD_SUM      = 4'd8,
      CMD_NORM     = 4'd9,
      CMD_ROUND    = 4'd10,
      CMD_ADD2     = 4'd11,
      CMD_COMMIT   = 4'd12
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       norm_done;
      logic       div_zero;
      logic       prod_inf;
   } dp_status_type;

endpackage

/* design/sfc_ifs.sv */
// valid/ready channel interfaces of the float coprocessor
// no dependencies
interface sfc_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  opcode;
   logic [4:0]  dest_index;
   logic [4:0]  first_index;
   logic [4:0]  second_index;
   logic [31:0] write_value;

   modport source (output valid, opcode, dest_index, first_index, second_index, write_value,
                   input ready);
   modport sink (input valid, opcode, dest_index, first_index, second_index, write_value,
                 output ready);
endinterface

interface sfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        condition_flag;

   modport source (output valid, read_data, condition_flag, input ready);
   modport sink (input valid, read_data, condition_flag, output ready);
endinterface

/* design/single_float_coprocessor.sv */
// Single-precision float coprocessor: one instruction per request item, one response
// item per instruction, 32 float registers, an accumulator and a compare condition.
// Instructions run one at a time through a shared datapath; a new request is taken
// only once the previous instruction has written back, while its response may still
// sit in the output register. Moves, control reads, negate, float-to-word and compares
// go from the register read straight to write-back. Add, sub and adda unpack, align,
// sum, normalize and round; multiply unpacks, multiplies, normalizes and rounds, and
// multiply-add runs a product pass and then a sum pass. Divide by a nonzero divisor runs
// the radix-2 divider, producing one quotient bit per cycle, then normalizes and rounds.
// Normalize shifts one or eight bits per cycle. Register file contents are undefined
// until written.
// depends on sfc_pkg, sfc_ifs, sfc_ctrl and sfc_dpath
module single_float_coprocessor
   import sfc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   sfc_req_if.sink  req_port,
   sfc_rsp_if.source rsp_port
);

   cmd_type       cmd;
   dp_status_type status;
   logic          req_ready;
   logic          rsp_valid;
   logic [31:0]   rsp_read_data;
   logic          rsp_condition_flag;

   sfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sfc_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_opcode         (req_port.opcode),
      .req_dest_index     (req_port.dest_index),
      .req_first_index    (req_port.first_index),
      .req_second_index   (req_port.second_index),
      .req_write_value    (req_port.write_value),
      .status             (status),
      .rsp_read_data      (rsp_read_data),
      .rsp_condition_flag (rsp_condition_flag)
   );

   assign req_port.ready          = req_ready;
   assign rsp_port.valid          = rsp_valid;
   assign rsp_port.read_data      = rsp_read_data;
   assign rsp_port.condition_flag = rsp_condition_flag;

   // an accepted item always starts a load into the datapath
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_ready) |-> (cmd == CMD_LOAD))
      else $error("accepted item without datapath load");

   // write-back never overruns a response still waiting
   a_commit_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_COMMIT) |-> (!rsp_valid || rsp_port.ready))
      else $error("commit while output register full");

   // after write-back a response is offered and the block is free again
   a_commit_resp: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_COMMIT) |=> (rsp_valid && req_ready))
      else $error("commit did not produce a response");

   // no item taken while an instruction is in flight
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_LOAD) |=> !req_ready)
      else $error("ready raised during execution");

endmodule

/* design/sfc_ram.sv */
// generic single-write, single-read RAM with registered read data
// no dependencies
module sfc_ram #(
   parameter int Width = 32,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/sfc_ctrl.sv */
// sequencing state machine of the float coprocessor
// depends on sfc_pkg; drives datapath commands from datapath status
module sfc_ctrl
   import sfc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output cmd_type       cmd
);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_READ   = 11'b000_0000_0010,
      S_MUL    = 11'b000_0000_0100,
      S_DIV    = 11'b000_0000_1000,
      S_DIVEND = 11'b000_0001_0000,
      S_ALIGN  = 11'b000_0010_0000,
      S_SUM    = 11'b000_0100_0000,
      S_NORM   = 11'b000_1000_0000,
      S_ROUND  = 11'b001_0000_0000,
      S_ADD2   = 11'b010_0000_0000,
      S_DONE   = 11'b100_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              pass2_ff, pass2_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pass2_in     = pass2_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = CMD_NONE;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               pass2_in = 1'b0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cnt_in = '0;
            unique case (status.op) inside
               OP_CVTSW: begin
                  cmd      = CMD_UNPACK;
                  state_in = S_NORM;
               end
               OP_ADD, OP_SUB, OP_ADDA: begin
                  cmd      = CMD_UNPACK;
                  state_in = S_ALIGN;
               end
               OP_MUL, OP_MADD: begin
                  cmd      = CMD_UNPACK;
                  state_in = S_MUL;
               end
               OP_DIV: begin
                  cmd      = CMD_UNPACK;
                  state_in = status.div_zero ? S_DONE : S_DIV;
               end
               default: begin
                  cmd      = CMD_SIMPLE;
                  state_in = S_DONE;
               end
            endcase
         end
         S_MUL: begin
            cmd      = CMD_MUL;
            state_in = S_NORM;
         end
         S_DIV: begin
            cmd    = CMD_DIV_STEP;
            cnt_in = cnt_ff + CntW'(1);
            if (cnt_ff == CntW'(DivSteps - 1)) begin
               state_in = S_DIVEND;
            end
         end
         S_DIVEND: begin
            cmd      = CMD_DIV_END;
            state_in = S_NORM;
         end
         S_ALIGN: begin
            cmd      = CMD_ALIGN;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd      = CMD_SUM;
            state_in = S_NORM;
         end
         S_NORM: begin
            if (status.norm_done) begin
               state_in = S_ROUND;
            end else begin
               cmd = CMD_NORM;
            end
         end
         S_ROUND: begin
            cmd = CMD_ROUND;
            // multiply-add rounds the product, then runs the sum pass unless the product rounded to infinity
            if (status.op == OP_MADD && !pass2_ff) begin
               pass2_in = 1'b1;
               state_in = S_ADD2;
            end else begin
               state_in = S_DONE;
            end
         end
         S_ADD2: begin
            cmd      = CMD_ADD2;
            state_in = status.prod_inf ? S_DONE : S_ALIGN;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd          = CMD_COMMIT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pass2_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pass2_ff     <= pass2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* design/sfc_dpath.sv */
// float datapath: register file, unpack, multiply, divide, align/add,
// normalize and round; depends on sfc_pkg and sfc_ram
module sfc_dpath
   import sfc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   input  logic [3:0]    req_opcode,
   input  logic [4:0]    req_dest_index,
   input  logic [4:0]    req_first_index,
   input  logic [4:0]    req_second_index,
   input  logic [31:0]   req_write_value,
   output dp_status_type status,
   output logic [31:0]   rsp_read_data,
   output logic          rsp_condition_flag
);

   typedef struct packed {
      logic        sign;
      exp_type     expo;
      logic [23:0] sig;
   } unpacked_type;

   function automatic logic [31:0] clamp(input logic [31:0] w);
      logic [31:0] r;
      r = w;
      if ((w & ExpMask) == ExpMask) begin
         r = (w & SignMask) | MaxFinite;
      end
      return r;
   endfunction

   // subnormals are brought to a leading one with a lowered exponent
   function automatic unpacked_type unpack(input logic [31:0] w);
      logic [23:0]  sig0;
      exp_type      e0;
      logic [4:0]   lz;
      unpacked_type u;
      sig0 = {(w[30:23] != 8'd0), w[22:0]};
      e0   = (w[30:23] == 8'd0) ? exp_type'(1) : exp_type'({3'b000, w[30:23]});
      lz   = 5'd24;
      for (int i = 0; i < 24; i++) begin
         if (sig0[i]) begin
            lz = 5'(23 - i);
         end
      end
      u.sign = w[31];
      u.sig  = sig0 << lz;
      u.expo = e0 - exp_type'({6'b000000, lz});
      return u;
   endfunction

   function automatic logic [31:0] float_to_word(input logic [31:0] u);
      logic [7:0]  ef;
      logic [31:0] base;
      logic [31:0] mag;
      logic [31:0] r;
      ef   = u[30:23];
      base = {8'h00, 1'b1, u[22:0]};
      mag  = (ef >= 8'd150) ? (base << 8'(ef - 8'd150)) : (base >> 8'(8'd150 - ef));
      if (ef >= 8'd158) begin
         // also covers infinity and nan
         r = u[31] ? SignMask : ~SignMask;
      end else if (ef < 8'd127) begin
         r = '0;
      end else begin
         r = u[31] ? (~mag + 32'd1) : mag;
      end
      return r;
   endfunction

   function automatic logic is_nan(input logic [31:0] w);
      return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
   endfunction

   opcode_type   op_ff;
   logic [4:0]   dest_ff;
   logic [31:0]  wv_ff;
   logic [31:0]  acc_ff;
   logic         cond_ff;
   logic         sa_ff, sb_ff;
   exp_type      ea_ff, eb_ff;
   logic [23:0]  siga_ff, sigb_ff;
   logic [24:0]  rem_ff;
   logic [DivSteps-1:0] q_ff;
   logic         sign_ff;
   exp_type      exp_ff;
   man_type      man_ff;
   man_type      aux_ff;
   logic         stk_ff;
   logic         esub_ff;
   logic         zsign_ff;
   logic [31:0]  result_ff;
   logic [31:0]  rd_out_ff;
   logic         cond_out_ff;

   logic [31:0]  ra, rb;
   logic         rd_en, wr_en;
   logic [RegAddrW-1:0] addr_a;
   logic [31:0]  wr_data;

   assign rd_en  = (cmd == CMD_LOAD);
   assign addr_a = (req_opcode == OP_MFC) ? req_dest_index : req_first_index;

   always_comb begin
      wr_en = 1'b0;
      if (cmd == CMD_COMMIT) begin
         case (op_ff) inside
            OP_MTC, OP_CVTSW, OP_CVTWS, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOV, OP_NEG,
            OP_MADD: wr_en = 1'b1;
            default: wr_en = 1'b0;
         endcase
      end
   end

   assign wr_data = (op_ff == OP_MTC) ? wv_ff : result_ff;

   // two copies of the register file give two read ports
   sfc_ram #(.Width(32), .Depth(RegCount)) u_regs_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (dest_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_a),
      .rd_data (ra)
   );

   sfc_ram #(.Width(32), .Depth(RegCount)) u_regs_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (dest_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (req_second_index),
      .rd_data (rb)
   );

   // operand preparation
   logic [31:0]  xa, xb;
   unpacked_type ua, ub;
   logic [31:0]  cvt_mag;

   always_comb begin
      if (cmd == CMD_ADD2) begin
         xa = clamp(acc_ff);
         xb = result_ff;
      end else begin
         xa = clamp(ra);
         xb = clamp(rb);
         if (op_ff == OP_SUB) begin
            xb[31] = ~xb[31];
         end
      end
      ua      = unpack(xa);
      ub      = unpack(xb);
      cvt_mag = ra[31] ? (~ra + 32'd1) : ra;
   end

   // alignment of the smaller addend
   logic        a_big;
   exp_type     e_big, e_small;
   logic [9:0]  shift_dist;
   man_type     m_big, m_small, m_shift, m_jam;

   always_comb begin
      a_big      = (ea_ff > eb_ff) || ((ea_ff == eb_ff) && (siga_ff >= sigb_ff));
      e_big      = a_big ? ea_ff : eb_ff;
      e_small    = a_big ? eb_ff : ea_ff;
      shift_dist = 10'(e_big - e_small);
      m_big      = {1'b0, (a_big ? siga_ff : sigb_ff), 25'd0};
      m_small    = {1'b0, (a_big ? sigb_ff : siga_ff), 25'd0};
      if (shift_dist >= 10'(ManW)) begin
         m_shift = '0;
         m_jam   = man_type'(m_small != '0);
      end else begin
         m_shift = m_small >> shift_dist;
         m_jam   = man_type'((m_small & ~({ManW{1'b1}} << shift_dist)) != '0);
      end
   end

   // sum, division step, product
   man_type     sum;
   logic        ge;
   logic [23:0] diff;
   logic [47:0] prod;

   always_comb begin
      sum  = esub_ff ? (man_ff - aux_ff) : (man_ff + aux_ff);
      ge   = (rem_ff >= {1'b0, sigb_ff});
      diff = ge ? 24'(rem_ff - {1'b0, sigb_ff}) : rem_ff[23:0];
      prod = siga_ff * sigb_ff;
   end

   // normalize conditions
   logic need_right, need_low, need_left, norm_done;

   always_comb begin
      need_right = man_ff[ManW-1];
      need_low   = (exp_ff < exp_type'(1));
      need_left  = !man_ff[ManW-2] && (man_ff != '0) && (exp_ff > exp_type'(1));
      norm_done  = !need_right && !need_low && !need_left;
   end

   // rounding to nearest even
   logic [23:0] keep;
   logic        round_up;
   logic [24:0] rsum;
   logic [23:0] sigf;
   exp_type     erd;
   logic [31:0] rounded;

   always_comb begin
      keep     = man_ff[48:25];
      round_up = man_ff[24] && ((man_ff[23:0] != 24'd0) || stk_ff || keep[0]);
      rsum     = {1'b0, keep} + 25'(round_up);
      if (rsum[24]) begin
         sigf = rsum[24:1];
         erd  = exp_ff + exp_type'(1);
      end else begin
         sigf = rsum[23:0];
         erd  = exp_ff;
      end
      if (sigf[23] && (erd >= exp_type'(255))) begin
         rounded = {sign_ff, 8'hFF, 23'd0};
      end else begin
         rounded = {sign_ff, (sigf[23] ? erd[7:0] : 8'd0), sigf[22:0]};
      end
   end

   // compares work on raw words
   logic both_zero, any_nan, cmp_lt, cmp_eq, cond_next;

   always_comb begin
      both_zero = ((ra[30:0] | rb[30:0]) == 31'd0);
      any_nan   = is_nan(ra) || is_nan(rb);
      cmp_eq    = !any_nan && ((ra == rb) || both_zero);
      if (ra[31] != rb[31]) begin
         cmp_lt = ra[31];
      end else if (ra[31]) begin
         cmp_lt = ra[30:0] > rb[30:0];
      end else begin
         cmp_lt = ra[30:0] < rb[30:0];
      end
      cmp_lt = cmp_lt && !any_nan && !both_zero;
      case (op_ff)
         OP_CLT:  cond_next = cmp_lt;
         OP_CEQ:  cond_next = cmp_eq;
         default: cond_next = cond_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cond_ff <= 1'b0;
      end else if (cmd == CMD_COMMIT) begin
         cond_ff <= cond_next;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd)
         CMD_LOAD: begin
            op_ff   <= opcode_type'(req_opcode);
            dest_ff <= req_dest_index;
            wv_ff   <= req_write_value;
         end
         CMD_SIMPLE: begin
            case (op_ff)
               OP_NEG:   result_ff <= ra ^ SignMask;
               OP_CVTWS: result_ff <= float_to_word(ra);
               default:  result_ff <= ra;
            endcase
         end
         CMD_UNPACK, CMD_ADD2: begin
            sa_ff   <= ua.sign;
            ea_ff   <= ua.expo;
            siga_ff <= ua.sig;
            sb_ff   <= ub.sign;
            eb_ff   <= ub.expo;
            sigb_ff <= ub.sig;
            rem_ff  <= {1'b0, ua.sig};
            q_ff    <= '0;
            if (cmd == CMD_UNPACK) begin
               // divide by zero answer, used only when the divisor is zero
               result_ff <= (xa[30:0] == 31'd0) ? QnanWord
                                                : ((xa ^ xb) & SignMask) | ExpMask;
               // integer source placed with its top bit at the 1.0 position
               sign_ff <= ra[31];
               man_ff  <= {1'b0, cvt_mag, 17'd0};
               exp_ff  <= exp_type'(158);
               stk_ff  <= 1'b0;
            end
         end
         CMD_MUL: begin
            man_ff  <= {prod, 2'b00};
            exp_ff  <= ea_ff + eb_ff - exp_type'(127);
            sign_ff <= sa_ff ^ sb_ff;
            stk_ff  <= 1'b0;
         end
         CMD_DIV_STEP: begin
            rem_ff <= {diff, 1'b0};
            q_ff   <= {q_ff[DivSteps-2:0], ge};
         end
         CMD_DIV_END: begin
            man_ff  <= {1'b0, q_ff, 22'd0};
            stk_ff  <= (rem_ff != 25'd0);
            exp_ff  <= ea_ff - eb_ff + exp_type'(127);
            sign_ff <= sa_ff ^ sb_ff;
         end
         CMD_ALIGN: begin
            man_ff   <= m_big;
            aux_ff   <= m_shift | m_jam;
            exp_ff   <= e_big;
            sign_ff  <= a_big ? sa_ff : sb_ff;
            esub_ff  <= sa_ff ^ sb_ff;
            zsign_ff <= sa_ff & sb_ff;
            stk_ff   <= 1'b0;
         end
         CMD_SUM: begin
            man_ff <= sum;
            if (sum == '0) begin
               sign_ff <= zsign_ff;
            end
         end
         CMD_NORM: begin
            if (need_right) begin
               stk_ff <= stk_ff | man_ff[0];
               man_ff <= man_ff >> 1;
               exp_ff <= exp_ff + exp_type'(1);
            end else if (need_low) begin
               if (exp_ff <= exp_type'(-7)) begin
                  stk_ff <= stk_ff | (man_ff[7:0] != 8'd0);
                  man_ff <= man_ff >> 8;
                  exp_ff <= exp_ff + exp_type'(8);
               end else begin
                  stk_ff <= stk_ff | man_ff[0];
                  man_ff <= man_ff >> 1;
                  exp_ff <= exp_ff + exp_type'(1);
               end
            end else if (need_left) begin
               if ((man_ff[48:41] == 8'd0) && (exp_ff >= exp_type'(9))) begin
                  man_ff <= man_ff << 8;
                  exp_ff <= exp_ff - exp_type'(8);
               end else begin
                  man_ff <= man_ff << 1;
                  exp_ff <= exp_ff - exp_type'(1);
               end
            end
         end
         CMD_ROUND: begin
            result_ff <= rounded;
         end
         CMD_COMMIT: begin
            if (op_ff == OP_ADDA) begin
               acc_ff <= result_ff;
            end
            case (op_ff)
               OP_MFC: rd_out_ff <= ra;
               OP_CFC: begin
                  if (dest_ff == 5'd0) begin
                     rd_out_ff <= Ctrl0Word;
                  end else if (dest_ff == 5'd31) begin
                     rd_out_ff <= {8'd0, cond_ff, 23'd0};
                  end else begin
                     rd_out_ff <= '0;
                  end
               end
               default: rd_out_ff <= '0;
            endcase
            cond_out_ff <= cond_next;
         end
         default: begin
         end
      endcase
   end

   assign status.op        = op_ff;
   assign status.norm_done = norm_done;
   assign status.div_zero  = (rb[30:0] == 31'd0);
   assign status.prod_inf  = (result_ff[30:23] == 8'hFF);

   assign rsp_read_data      = rd_out_ff;
   assign rsp_condition_flag = cond_out_ff;

endmodule

/* test/tb_sfc_ifs.sv */
// note on the channel interfaces used by the float coprocessor testbench
// the interfaces themselves live in design/sfc_ifs.sv; this file only
// holds the testbench-side record of one expected response item
package tb_sfc_types;
   typedef struct {
      logic [31:0] read_data;
      logic        condition_flag;
   } fpu_response_type;
endpackage

/* test/tb_top.sv */
// testbench of single_float_coprocessor: directed instruction table, then random instructions
// checked against a behavioral float predictor; depends on sfc_pkg, sfc_ifs, tb_sfc_types
module tb_top;
   import sfc_pkg::*;
   import tb_sfc_types::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      opcode_type  op;
      logic [4:0]  dest;
      logic [4:0]  src_a;
      logic [4:0]  src_b;
      logic [31:0] wval;
      logic        fixed;
      logic [31:0] fixed_rd;
      logic        fixed_flag;
   } fpu_instr_type;

   logic clock = 0;
   logic reset = 1;
   logic quiet = 0;
   int   fail_count = 0;
   int   stall_left = 0;

   // predictor state
   logic [31:0] fp_regs [RegCount];
   logic [31:0] acc_word;
   logic        cond_bit;
   logic        reg_written [RegCount];
   logic        acc_written;

   fpu_response_type pending_results[$];

   sfc_req_if req_bus();
   sfc_rsp_if rsp_bus();

   single_float_coprocessor u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] clamp_word(logic [31:0] w);
      if ((w & ExpMask) == ExpMask) return (w & SignMask) | MaxFinite;
      return w;
   endfunction

   function automatic logic is_nan(logic [31:0] w);
      return (w[30:23] == 8'hFF) && (w[22:0] != 0);
   endfunction

   // exact widening of a single to a double
   function automatic real single_to_real(logic [31:0] w);
      logic [63:0] d;
      logic [23:0] sig;
      int          e;
      e = w[30:23];
      if (e == 255)
         d = {w[31], 11'h7FF, (w[22:0] != 0) ? 52'h8_0000_0000_0000 : 52'h0};
      else if (w[30:0] == 0)
         d = {w[31], 63'h0};
      else begin
         sig = {e != 0, w[22:0]};
         if (e == 0) e = 1;
         while (!sig[23]) begin
            sig = sig << 1;
            e--;
         end
         d = {w[31], 11'(e - 127 + 1023), sig[22:0], 29'h0};
      end
      return $bitstoreal(d);
   endfunction

   // round a double to single, nearest even, with subnormals and overflow
   function automatic logic [31:0] round_single(real r);
      logic [63:0] d;
      logic [63:0] sig;
      logic [63:0] kept;
      logic        half;
      logic        sticky;
      int          ue;
      int          sh;
      d = $realtobits(r);
      if (d[62:52] == 11'h7FF)
         return (d[51:0] != 0) ? QnanWord : {d[63], 8'hFF, 23'h0};
      if (d[62:52] == 0) return {d[63], 31'h0};
      ue = int'(d[62:52]) - 1023;
      sig = {11'h0, 1'b1, d[51:0]};
      sh = (ue >= -126) ? 29 : 29 + (-126 - ue);
      if (sh > 60) return {d[63], 31'h0};
      kept = sig >> sh;
      half = sig[sh-1];
      sticky = (sig & ((64'd1 << (sh - 1)) - 1)) != 0;
      if (half && (sticky || kept[0])) kept++;
      if (ue >= -126) begin
         if (kept[24]) begin
            kept = kept >> 1;
            ue++;
         end
         if (ue > 127) return {d[63], 8'hFF, 23'h0};
         return {d[63], 8'(ue + 127), kept[22:0]};
      end
      return {d[63], kept[30:0]};
   endfunction

   function automatic logic [31:0] float_quotient(logic [31:0] n, logic [31:0] q);
      n = clamp_word(n);
      q = clamp_word(q);
      if (q[30:0] == 0) begin
         if (n[30:0] == 0) return QnanWord;
         return ((n ^ q) & SignMask) | ExpMask;
      end
      return round_single(single_to_real(n) / single_to_real(q));
   endfunction

   function automatic logic [31:0] float_to_int(logic [31:0] w);
      real f;
      if (is_nan(w)) return w[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      f = single_to_real(w);
      if (f >= 2147483648.0) return 32'h7FFF_FFFF;
      if (f < -2147483648.0) return 32'h8000_0000;
      return 32'($rtoi(f));
   endfunction

   function automatic real arith_operand(logic [31:0] w);
      return single_to_real(clamp_word(w));
   endfunction

   // runs one instruction on the predictor state and returns its response
   function automatic fpu_response_type fpu_execute(fpu_instr_type ins);
      fpu_response_type res;
      logic [31:0]      ra;
      logic [31:0]      rb;
      logic [31:0]      prod;
      logic [31:0]      wr;
      logic             writes;
      ra = fp_regs[ins.src_a];
      rb = fp_regs[ins.src_b];
      res.read_data = 0;
      writes = 1;
      wr = 0;
      case (ins.op)
         OP_MTC:   wr = ins.wval;
         OP_MFC: begin
            res.read_data = fp_regs[ins.dest];
            writes = 0;
         end
         OP_CFC: begin
            if (ins.dest == 0) res.read_data = Ctrl0Word;
            else if (ins.dest == 31) res.read_data = cond_bit ? 32'h0080_0000 : 32'h0;
            writes = 0;
         end
         OP_CTC:   writes = 0;
         OP_CVTSW: wr = round_single(real'(int'(ra)));
         OP_CVTWS: wr = float_to_int(ra);
         OP_ADD:   wr = round_single(arith_operand(ra) + arith_operand(rb));
         OP_SUB:   wr = round_single(arith_operand(ra) - arith_operand(rb));
         OP_MUL:   wr = round_single(arith_operand(ra) * arith_operand(rb));
         OP_DIV:   wr = float_quotient(ra, rb);
         OP_MOV:   wr = ra;
         OP_NEG:   wr = ra ^ SignMask;
         OP_ADDA: begin
            acc_word = round_single(arith_operand(ra) + arith_operand(rb));
            acc_written = 1;
            writes = 0;
         end
         OP_MADD: begin
            prod = round_single(arith_operand(ra) * arith_operand(rb));
            wr = round_single(arith_operand(acc_word) + single_to_real(prod));
         end
         OP_CLT: begin
            cond_bit = !is_nan(ra) && !is_nan(rb) && (single_to_real(ra) < single_to_real(rb));
            writes = 0;
         end
         default: begin
            cond_bit = !is_nan(ra) && !is_nan(rb) && (single_to_real(ra) == single_to_real(rb));
            writes = 0;
         end
      endcase
      if (writes) begin
         fp_regs[ins.dest] = wr;
         reg_written[ins.dest] = 1;
      end
      res.condition_flag = cond_bit;
      return res;
   endfunction

   function automatic fpu_instr_type instr(opcode_type op, int d, int a, int b,
                                           logic [31:0] wv = 0, logic fx = 0,
                                           logic [31:0] frd = 0, logic ff = 0);
      fpu_instr_type ins;
      ins.op = op;
      ins.dest = 5'(d);
      ins.src_a = 5'(a);
      ins.src_b = 5'(b);
      ins.wval = wv;
      ins.fixed = fx;
      ins.fixed_rd = frd;
      ins.fixed_flag = ff;
      return ins;
   endfunction

   function automatic logic [31:0] random_word();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 7))
         0: w = {w[31], 8'($urandom_range(120, 165)), w[22:0]};
         1: w = {w[31], 8'h00, w[22:0]};
         2: w = 32'($signed(10'($urandom)));
         3: begin
            case ($urandom_range(0, 5))
               0: w = {w[31], 31'h0};
               1: w = {w[31], ExpMask[30:0]};
               2: w = {w[31], 8'hFF, w[22:0] | 23'h1};
               3: w = {w[31], MaxFinite[30:0]};
               4: w = {w[31], 8'h7F, 23'h0};
               default: w = {w[31], 8'h4F, 23'h0};
            endcase
         end
         4: w = {w[31], 8'($urandom_range(100, 150)), 23'($urandom_range(0, 15))};
         default: ;
      endcase
      return w;
   endfunction

   function automatic fpu_instr_type random_instr();
      fpu_instr_type ins;
      logic          ok;
      ins = instr(opcode_type'($urandom_range(0, 15)), $urandom_range(0, 31),
                  $urandom_range(0, 31), $urandom_range(0, 31), random_word());
      // keep reads on written storage, else turn it into a register load
      case (ins.op)
         OP_MTC, OP_CFC, OP_CTC: ok = 1;
         OP_MFC:                 ok = reg_written[ins.dest];
         OP_CVTSW, OP_CVTWS, OP_MOV, OP_NEG: ok = reg_written[ins.src_a];
         OP_MADD: ok = acc_written && reg_written[ins.src_a] && reg_written[ins.src_b];
         default: ok = reg_written[ins.src_a] && reg_written[ins.src_b];
      endcase
      if (!ok) begin
         ins.op = OP_MTC;
         if (!reg_written[ins.src_a]) ins.dest = ins.src_a;
         else ins.dest = ins.src_b;
      end
      return ins;
   endfunction

   task automatic issue(fpu_instr_type ins);
      fpu_response_type res;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid <= 1;
      req_bus.opcode <= ins.op;
      req_bus.dest_index <= ins.dest;
      req_bus.first_index <= ins.src_a;
      req_bus.second_index <= ins.src_b;
      req_bus.write_value <= ins.wval;
      do @(posedge clock); while (!req_bus.ready);
      res = fpu_execute(ins);
      if (ins.fixed) begin
         res.read_data = ins.fixed_rd;
         res.condition_flag = ins.fixed_flag;
      end
      pending_results.push_back(res);
   endtask

   // response side: check and random stalls
   always @(posedge clock) begin
      fpu_response_type want;
      if (rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("response item with nothing expected");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, rsp_bus.read_data);
               fail_count++;
            end
            if (rsp_bus.condition_flag !== want.condition_flag) begin
               $error("condition_flag: expected %b, got %b", want.condition_flag,
                      rsp_bus.condition_flag);
               fail_count++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_bus.ready <= 0;
      end else begin
         rsp_bus.ready <= 1;
      end
   end

   initial begin
      fpu_instr_type directed[$];
      directed = '{
         instr(OP_CFC, 0, 0, 0, 0, 1, Ctrl0Word, 0),
         instr(OP_CFC, 31, 0, 0, 0, 1, 32'h0, 0),
         instr(OP_CFC, 5, 0, 0, 0, 1, 32'h0, 0),
         instr(OP_CTC, 31, 0, 0, 32'hFFFF_FFFF, 1, 32'h0, 0),
         instr(OP_MTC, 1, 0, 0, 32'h7F80_0000, 1, 32'h0, 0),
         instr(OP_MTC, 2, 0, 0, 32'hFF80_0000),
         instr(OP_MTC, 3, 0, 0, QnanWord),
         instr(OP_MTC, 4, 0, 0, 32'h0000_0000),
         instr(OP_MTC, 5, 0, 0, 32'h8000_0000),
         instr(OP_MTC, 6, 0, 0, MaxFinite),
         instr(OP_MTC, 7, 0, 0, 32'h0000_0001),
         instr(OP_MTC, 31, 0, 0, 32'h3F80_0000),
         instr(OP_MFC, 1, 0, 0, 0, 1, 32'h7F80_0000, 0),
         instr(OP_DIV, 9, 31, 4),
         instr(OP_MFC, 9, 0, 0, 0, 1, 32'h7F80_0000, 0),
         instr(OP_DIV, 10, 4, 5),
         instr(OP_MFC, 10, 0, 0, 0, 1, QnanWord, 0),
         instr(OP_CVTWS, 11, 3, 0),
         instr(OP_MFC, 11, 0, 0, 0, 1, 32'h7FFF_FFFF, 0),
         instr(OP_CVTSW, 12, 5, 0),
         instr(OP_MFC, 12, 0, 0, 0, 1, 32'hCF00_0000, 0),
         instr(OP_ADD, 13, 1, 6), instr(OP_SUB, 14, 2, 6), instr(OP_MUL, 15, 7, 7),
         instr(OP_MOV, 16, 3, 0), instr(OP_NEG, 17, 4, 0), instr(OP_ADDA, 0, 31, 31),
         instr(OP_MADD, 18, 6, 6),
         instr(OP_CLT, 0, 4, 31, 0, 1, 32'h0, 1),
         instr(OP_CFC, 31, 0, 0, 0, 1, 32'h0080_0000, 1),
         instr(OP_CEQ, 0, 3, 3, 0, 1, 32'h0, 0),
         instr(OP_CEQ, 0, 4, 5, 0, 1, 32'h0, 1)
      };
      cond_bit = 0;
      acc_word = 0;
      acc_written = 0;
      for (int i = 0; i < RegCount; i++) begin
         fp_regs[i] = 0;
         reg_written[i] = 0;
      end
      req_bus.valid <= 0;
      req_bus.opcode <= OP_MTC;
      req_bus.dest_index <= 0;
      req_bus.first_index <= 0;
      req_bus.second_index <= 0;
      req_bus.write_value <= 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      foreach (directed[i]) issue(directed[i]);
      for (int n = 0; n < 1300; n++) begin
         if (n == 600) begin
            // drain everything before going on
            req_bus.valid <= 0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         if (n == 1150) quiet <= 1;
         issue(random_instr());
      end
      req_bus.valid <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("** single_float_coprocessor: PASSED **");
      else
         $display("** single_float_coprocessor: FAILED **");
      $finish;
   end

   initial begin
      #10ms;
      $display("** single_float_coprocessor: FAILED **");
      $finish;
   end

endmodule

/* sim.f */
design/sfc_pkg.sv
design/sfc_ifs.sv
design/sfc_ram.sv
design/sfc_ctrl.sv
design/sfc_dpath.sv
design/single_float_coprocessor.sv
test/tb_sfc_ifs.sv
test/tb_top.sv
